@@ design/cswd_pkg.sv @@
package cswd_pkg;
  localparam int MaxElements = 8;
  localparam int ValueWidth = 16;
  localparam int StoreDepth = (MaxElements + 1) * (MaxElements + 2) / 2;
  localparam int IdxW = $clog2(MaxElements);
  localparam int CntW = $clog2(MaxElements + 1);
  localparam int SIdxW = $clog2(StoreDepth);
  localparam int SCntW = $clog2(StoreDepth + 1);

  typedef enum logic [1:0] {
    REQ_RESTART = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_DIST = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END = 2'd1,
    CFG_COUNT = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESTART,
    ST_ADV_UP,
    ST_ADV_FILL,
    ST_EMIT_SET,
    ST_GAP,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_EMIT_RD,
    ST_EMIT_DIST
  } state_t;
endpackage

@@ design/combination_stepper_with_distances.sv @@
// Channel | Ports                                  | Handshake
// config  | cfg_we, cfg_index, cfg_data            | write when cfg_we high
// input   | in_req_type, in_distance_total         | start & !busy
// result  | out_value, out_position, out_last,     | out_strobe, one cycle
//         | out_advanced                           |
// Restart writes start+i into each element, then emits the set; advance
// scans down, increments, refills the elements above, then emits the set.
// Distances: one gap per cycle into the store, an insertion sort in the
// store (one write, one read port), then each entry is read and emitted.
// Reset (synchronous, rst_n low) loads registers and the set 0..7.
// The receiver cannot stall: each result is shown for one cycle.
module combination_stepper_with_distances (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_distance_total,
  output logic        out_strobe,
  output logic signed [16:0] out_value,
  output logic [5:0]  out_position,
  output logic        out_last,
  output logic        out_advanced
);
  localparam int VW = cswd_pkg::ValueWidth;
  localparam int IW = cswd_pkg::IdxW;
  localparam int CW = cswd_pkg::CntW;
  localparam int SW = cswd_pkg::SIdxW;
  localparam int NW = cswd_pkg::SCntW;

  cswd_pkg::state_t state_r, state_nxt;
  logic [15:0] start_r, end_r;
  logic [3:0]  count_r;
  logic [VW-1:0] comb_r [cswd_pkg::MaxElements];
  logic [15:0] m_r;
  logic [CW-1:0] k_r;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [1:0]  gph_r, gph_nxt;   // gap phase: 0 elem,1 M-elem,2 M,3 pair
  logic        adv_r, adv_nxt;
  logic [NW-1:0] n_r, n_nxt;     // entries in store
  logic [SW-1:0] si_r, si_nxt;   // outer sort index
  logic [SW:0]   sj_r, sj_nxt;   // inner index + 1 (0 means below bottom)
  logic [16:0] key_r, key_nxt;
  logic [16:0] mem [cswd_pkg::StoreDepth];
  logic [16:0] rd_r;
  logic        we;
  logic [SW-1:0] waddr, raddr;
  logic [16:0] wdata;
  logic        rst_set;

  // effective element count
  logic [CW-1:0] k_eff;
  always_comb begin
    if (count_r == 4'd0) k_eff = CW'(1);
    else if (count_r > 4'(cswd_pkg::MaxElements)) k_eff = CW'(cswd_pkg::MaxElements);
    else k_eff = CW'(count_r);
  end

  assign busy = (state_r != cswd_pkg::ST_IDLE);

  // shared arithmetic: one increment with bound compare
  logic [VW:0] inc;
  logic signed [19:0] bound;
  always_comb begin
    inc = {1'b0, comb_r[i_r]} + (VW+1)'(1);
    bound = $signed({4'd0, end_r}) - $signed(20'(k_r)) + $signed(20'(i_r)) + 20'sd1;
  end

  // gap unit: one subtraction per cycle
  logic [16:0] gap;
  always_comb begin
    unique case (gph_r)
      2'd0: gap = 17'(comb_r[i_r]);
      2'd1: gap = 17'(m_r) - 17'(comb_r[i_r]);
      2'd2: gap = 17'(m_r);
      default: gap = 17'(comb_r[i_r]) - 17'(comb_r[j_r]);
    endcase
  end

  // store: one write port and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  logic out_nxt;
  logic signed [16:0] oval_nxt;
  logic [5:0] opos_nxt;
  logic olast_nxt;

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; gph_nxt = gph_r; adv_nxt = adv_r;
    n_nxt = n_r; si_nxt = si_r; sj_nxt = sj_r; key_nxt = key_r;
    we = 1'b0; waddr = n_r[SW-1:0]; wdata = gap; raddr = si_r;
    out_nxt = 1'b0; oval_nxt = '0; opos_nxt = '0; olast_nxt = 1'b0;
    unique case (state_r)
      cswd_pkg::ST_IDLE: begin
        if (start) begin
          i_nxt = '0;
          n_nxt = '0;
          gph_nxt = 2'd0;
          unique case (cswd_pkg::req_t'(in_req_type))
            cswd_pkg::REQ_RESTART: state_nxt = cswd_pkg::ST_RESTART;
            cswd_pkg::REQ_ADVANCE: begin
              state_nxt = cswd_pkg::ST_ADV_UP;
              i_nxt = IW'(k_eff - CW'(1));
            end
            cswd_pkg::REQ_DIST: state_nxt = cswd_pkg::ST_GAP;
            default: state_nxt = cswd_pkg::ST_IDLE;
          endcase
        end
      end
      cswd_pkg::ST_RESTART: begin
        adv_nxt = 1'b1;
        if (CW'(i_r) == k_r - CW'(1)) begin
          i_nxt = '0; state_nxt = cswd_pkg::ST_EMIT_SET;
        end else i_nxt = i_r + IW'(1);
      end
      cswd_pkg::ST_ADV_UP: begin
        if ($signed({3'd0, inc}) <= bound) begin
          adv_nxt = 1'b1;
          if (CW'(i_r) == k_r - CW'(1)) begin
            i_nxt = '0; state_nxt = cswd_pkg::ST_EMIT_SET;
          end else begin
            i_nxt = i_r + IW'(1); state_nxt = cswd_pkg::ST_ADV_FILL;
          end
        end else if (i_r == '0) begin
          adv_nxt = 1'b0; state_nxt = cswd_pkg::ST_EMIT_SET;
        end else i_nxt = i_r - IW'(1);
      end
      cswd_pkg::ST_ADV_FILL: begin
        if (CW'(i_r) == k_r - CW'(1)) begin
          i_nxt = '0; state_nxt = cswd_pkg::ST_EMIT_SET;
        end else i_nxt = i_r + IW'(1);
      end
      cswd_pkg::ST_EMIT_SET: begin
        out_nxt = 1'b1;
        oval_nxt = 17'(comb_r[i_r]);
        opos_nxt = 6'(i_r);
        olast_nxt = (CW'(i_r) == k_r - CW'(1));
        if (olast_nxt) state_nxt = cswd_pkg::ST_IDLE;
        else i_nxt = i_r + IW'(1);
      end
      cswd_pkg::ST_GAP: begin
        we = 1'b1;
        n_nxt = n_r + NW'(1);
        unique case (gph_r)
          2'd0: gph_nxt = 2'd1;
          2'd1: begin
            if (CW'(i_r) == k_r - CW'(1)) gph_nxt = 2'd2;
            else begin gph_nxt = 2'd0; i_nxt = i_r + IW'(1); end
          end
          2'd2: begin
            if (k_r == CW'(1)) begin
              si_nxt = SW'(1); state_nxt = cswd_pkg::ST_SORT_RD;
            end else begin
              gph_nxt = 2'd3; i_nxt = IW'(k_r - CW'(1)); j_nxt = IW'(k_r - CW'(2));
            end
          end
          default: begin
            if (j_r != '0) j_nxt = j_r - IW'(1);
            else if (i_r == IW'(1)) begin
              si_nxt = SW'(1); state_nxt = cswd_pkg::ST_SORT_RD;
            end else begin
              i_nxt = i_r - IW'(1); j_nxt = i_r - IW'(2);
            end
          end
        endcase
      end
      // read store[si] for the key; when si reaches n, go to emit
      cswd_pkg::ST_SORT_RD: begin
        if (NW'(si_r) >= n_r) begin
          si_nxt = '0; state_nxt = cswd_pkg::ST_EMIT_RD;
        end else begin
          raddr = si_r;
          sj_nxt = {1'b0, si_r};
          state_nxt = cswd_pkg::ST_SORT_CMP;
        end
      end
      cswd_pkg::ST_SORT_CMP: begin
        // rd_r is the key read in ST_SORT_RD; store[sj-1] is requested for ST_SORT_WR
        if (sj_r == {1'b0, si_r} && key_r != rd_r) key_nxt = rd_r;
        raddr = SW'(sj_r - (SW+1)'(1));
        state_nxt = cswd_pkg::ST_SORT_WR;
        if (sj_r == {1'b0, si_r}) key_nxt = rd_r;
      end
      cswd_pkg::ST_SORT_WR: begin
        if (sj_r != '0 && $signed(rd_r) > $signed(key_r)) begin
          we = 1'b1; waddr = SW'(sj_r); wdata = rd_r;
          sj_nxt = sj_r - (SW+1)'(1);
          raddr = SW'(sj_r - (SW+1)'(2));
        end else begin
          we = 1'b1; waddr = SW'(sj_r); wdata = key_r;
          si_nxt = si_r + SW'(1);
          state_nxt = cswd_pkg::ST_SORT_RD;
        end
      end
      cswd_pkg::ST_EMIT_RD: begin
        raddr = si_r;
        state_nxt = cswd_pkg::ST_EMIT_DIST;
      end
      cswd_pkg::ST_EMIT_DIST: begin
        out_nxt = 1'b1;
        oval_nxt = rd_r;
        opos_nxt = 6'(si_r);
        olast_nxt = (NW'(si_r) == n_r - NW'(1));
        if (olast_nxt) state_nxt = cswd_pkg::ST_IDLE;
        else begin si_nxt = si_r + SW'(1); state_nxt = cswd_pkg::ST_EMIT_RD; end
      end
      default: state_nxt = cswd_pkg::ST_IDLE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cswd_pkg::ST_IDLE;
      out_strobe <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_strobe <= out_nxt;
    end
  end

  // working registers and outputs
  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; gph_r <= gph_nxt; adv_r <= adv_nxt;
    n_r <= n_nxt; si_r <= si_nxt; sj_r <= sj_nxt; key_r <= key_nxt;
    out_value <= oval_nxt;
    out_position <= opos_nxt;
    out_last <= olast_nxt;
    out_advanced <= out_nxt && (state_r == cswd_pkg::ST_EMIT_SET) && adv_r;
    if (state_r == cswd_pkg::ST_IDLE && start) begin
      k_r <= k_eff;
      m_r <= in_distance_total;
    end
  end

  // configuration and set registers
  assign rst_set = !rst_n;
  always_ff @(posedge clk) begin
    if (rst_set) begin
      start_r <= '0;
      end_r <= 16'd7;
      count_r <= 4'd8;
      for (int e = 0; e < cswd_pkg::MaxElements; e++) comb_r[e] <= VW'(e);
    end else begin
      if (cfg_we) begin
        unique case (cswd_pkg::cfg_idx_t'(cfg_index))
          cswd_pkg::CFG_START: start_r <= cfg_data;
          cswd_pkg::CFG_END: end_r <= cfg_data;
          cswd_pkg::CFG_COUNT: count_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state_r)
        cswd_pkg::ST_RESTART: comb_r[i_r] <= VW'(start_r) + VW'(i_r);
        cswd_pkg::ST_ADV_UP: comb_r[i_r] <= inc[VW-1:0];
        cswd_pkg::ST_ADV_FILL: comb_r[i_r] <= comb_r[i_r - IW'(1)] + VW'(1);
        default: ;
      endcase
    end
  end
endmodule
